FILE: rtl/core/rhc_pkg.sv
package rhc_pkg;

  localparam int PIX_W = 8;
  localparam int HUE_W = 9;
  localparam int SAT_W = 8;
  localparam int VAL_W = 8;

  // Quotient of 60*|diff|/delta never exceeds 60.
  localparam int HUE_Q_W = 6;

  localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 9'd240;
  localparam logic [HUE_W-1:0] HUE_FULL       = 9'd360;

  // Lane slots in the divider cells.
  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } rhc_sel_t;

  typedef struct packed {
    rhc_sel_t sel;
    logic     neg;
    logic     grey;
    logic     black;
  } rhc_side_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rhc_in_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [VAL_W-1:0] brightness;
  } rhc_out_t;

endpackage

FILE: rtl/core/rgb_to_hsv_converter_unit.sv
// RGB to HSV pixel converter.
//
// Input channel: in_valid / in_ready carry one beat per pixel, in_data holds
// the red, green and blue channels. Output channel: out_valid / out_ready
// carry one beat per pixel with hue (0..359 degrees), saturation (255 = 1.0)
// and brightness (the largest channel), in input order.
//
// Throughput: one pixel per clock while out_ready stays high. The pipe is a
// row of STEPS divider cells, STEPS = max(CHANNEL_BITS, 6): each cell
// retires one quotient bit of both the hue and the saturation division,
// and a front stage (max/min, numerators) and an output register bracket
// the row.
//
// Every stage has its own valid bit and holds its beat while the next stage
// is full, so bubbles close up and a new pixel is taken while a finished
// result waits on out_ready. A stall at the receiver backs up stage by
// stage; in_ready drops only when every stage holds a beat.
// Reset clears the stage valid bits; the data registers are not reset.
module rgb_to_hsv_converter_unit import rhc_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rhc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rhc_out_t out_data
);

  localparam int W     = CHANNEL_BITS;
  localparam int STEPS = (CHANNEL_BITS > HUE_Q_W) ? CHANNEL_BITS : HUE_Q_W;

  // Hop k sits between stage k-1 and stage k; hop 0 leaves the front stage.
  logic              hop_valid [STEPS+1];
  logic              hop_ready [STEPS+1];
  rhc_side_t         hop_side  [STEPS+1];
  logic [1:0][W-1:0]     hop_rem [STEPS+1];
  logic [1:0][STEPS-1:0] hop_quo [STEPS+1];
  logic [1:0][W-1:0]     hop_div [STEPS+1];

  rhc_front #(.W(W), .S(STEPS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (hop_valid[0]),
    .out_ready (hop_ready[0]),
    .out_side  (hop_side[0]),
    .out_rem   (hop_rem[0]),
    .out_quo   (hop_quo[0]),
    .out_div   (hop_div[0])
  );

  // Advance one quotient bit per cell.
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    rhc_div_cell #(.W(W), .S(STEPS)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (hop_valid[k]),
      .in_ready  (hop_ready[k]),
      .in_side   (hop_side[k]),
      .in_rem    (hop_rem[k]),
      .in_quo    (hop_quo[k]),
      .in_div    (hop_div[k]),
      .out_valid (hop_valid[k+1]),
      .out_ready (hop_ready[k+1]),
      .out_side  (hop_side[k+1]),
      .out_rem   (hop_rem[k+1]),
      .out_quo   (hop_quo[k+1]),
      .out_div   (hop_div[k+1])
    );
  end

  // The final remainders are not needed; the quotients and divisors go on, and only max is used.
  rhc_back #(.W(W), .S(STEPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hop_valid[STEPS]),
    .in_ready  (hop_ready[STEPS]),
    .in_side   (hop_side[STEPS]),
    .in_quo    (hop_quo[STEPS]),
    .in_div    (hop_div[STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hue < HUE_FULL)
    else $error("hue out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> hop_valid[0] && out_valid && !out_ready)
    else $error("input stalled while the pipe had room");

endmodule

FILE: rtl/core/rhc_front.sv
module rhc_front import rhc_pkg::*; #(
  parameter int W = 8,
  parameter int S = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rhc_in_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rhc_side_t                 out_side,
  output logic [1:0][W-1:0]         out_rem,
  output logic [1:0][S-1:0]         out_quo,
  output logic [1:0][W-1:0]         out_div
);

  logic [W-1:0] r, g, b;
  logic [W-1:0] mx, mn, delta, op_a, op_b, mag;
  rhc_sel_t     sel;
  logic         neg;
  logic [W+5:0] num_hue;
  logic [2*W-1:0] num_sat;
  logic [W+S-1:0] hue_ext, sat_ext;

  logic             valid_r;
  rhc_side_t        side_r, side_nxt;
  logic [1:0][W-1:0] rem_r, rem_nxt, div_r, div_nxt;
  logic [1:0][S-1:0] quo_r, quo_nxt;

  // Drop input bits above the channel width.
  assign r = W'({{W{1'b0}}, in_data.red});
  assign g = W'({{W{1'b0}}, in_data.green});
  assign b = W'({{W{1'b0}}, in_data.blue});

  always_comb begin
    if (r >= g && r >= b) begin
      sel = SEL_RED;
      mx  = r;
    end else if (g >= b) begin
      sel = SEL_GREEN;
      mx  = g;
    end else begin
      sel = SEL_BLUE;
      mx  = b;
    end
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    delta = mx - mn;
  end

  always_comb begin
    case (sel)
      SEL_RED: begin
        op_a = g;
        op_b = b;
      end
      SEL_GREEN: begin
        op_a = b;
        op_b = r;
      end
      SEL_BLUE: begin
        op_a = r;
        op_b = g;
      end
      default: begin
        op_a = g;
        op_b = b;
      end
    endcase
    neg = op_a < op_b;
    mag = neg ? (op_b - op_a) : (op_a - op_b);
  end

  // 60*mag as 64*mag - 4*mag; delta*(2^W-1) as (delta<<W) - delta.
  assign num_hue = {mag, 6'b0} - {4'b0000, mag, 2'b00};
  assign num_sat = {delta, {W{1'b0}}} - {{W{1'b0}}, delta};
  assign hue_ext = (W+S)'(num_hue);
  assign sat_ext = (W+S)'(num_sat);

  always_comb begin
    side_nxt.sel   = sel;
    side_nxt.neg   = neg;
    side_nxt.grey  = (delta == '0);
    side_nxt.black = (mx == '0);
    rem_nxt[LANE_HUE] = hue_ext[W+S-1:S];
    quo_nxt[LANE_HUE] = hue_ext[S-1:0];
    div_nxt[LANE_HUE] = delta;
    rem_nxt[LANE_SAT] = sat_ext[W+S-1:S];
    quo_nxt[LANE_SAT] = sat_ext[S-1:0];
    div_nxt[LANE_SAT] = mx;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      side_r <= side_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      div_r  <= div_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_side  = side_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_div   = div_r;

endmodule

FILE: rtl/core/rhc_div_cell.sv
module rhc_div_cell import rhc_pkg::*; #(
  parameter int W = 8,
  parameter int S = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rhc_side_t         in_side,
  input  logic [1:0][W-1:0] in_rem,
  input  logic [1:0][S-1:0] in_quo,
  input  logic [1:0][W-1:0] in_div,
  output logic              out_valid,
  input  logic              out_ready,
  output rhc_side_t         out_side,
  output logic [1:0][W-1:0] out_rem,
  output logic [1:0][S-1:0] out_quo,
  output logic [1:0][W-1:0] out_div
);

  logic              valid_r;
  rhc_side_t         side_r;
  logic [1:0][W-1:0] rem_r, rem_nxt, div_r;
  logic [1:0][S-1:0] quo_r, quo_nxt;

  // One restoring step per lane: shift in the next numerator bit, try the
  // subtract, shift the quotient bit into the bottom of the same register.
  always_comb begin
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;
    for (int l = 0; l < 2; l++) begin
      trial = {in_rem[l], in_quo[l][S-1]};
      diff  = trial - {1'b0, in_div[l]};
      ge    = trial >= {1'b0, in_div[l]};
      rem_nxt[l] = ge ? diff[W-1:0] : trial[W-1:0];
      quo_nxt[l] = {in_quo[l][S-2:0], ge};
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      side_r <= in_side;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      div_r  <= in_div;
    end
  end

  assign out_valid = valid_r;
  assign out_side  = side_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_div   = div_r;

  a_hue_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !side_r.grey |-> rem_r[LANE_HUE] < div_r[LANE_HUE])
    else $error("hue partial remainder not below delta");

  a_sat_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !side_r.black |-> rem_r[LANE_SAT] < div_r[LANE_SAT])
    else $error("saturation partial remainder not below max");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(div_r))
    else $error("cell dropped a stalled beat");

endmodule

FILE: rtl/core/rhc_back.sv
module rhc_back import rhc_pkg::*; #(
  parameter int W = 8,
  parameter int S = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rhc_side_t         in_side,
  input  logic [1:0][S-1:0] in_quo,
  input  logic [1:0][W-1:0] in_div,
  output logic              out_valid,
  input  logic              out_ready,
  output rhc_out_t          out_data
);

  logic [HUE_Q_W-1:0] q;
  logic [HUE_W-1:0]   q_ext;
  logic               valid_r;
  rhc_out_t           data_r, data_nxt;

  assign q     = in_quo[LANE_HUE][HUE_Q_W-1:0];
  assign q_ext = HUE_W'(q);

  always_comb begin
    if (in_side.grey) begin
      data_nxt.hue = '0;
    end else begin
      case (in_side.sel)
        SEL_RED: begin
          // Negative result wraps to 300..359; a zero quotient stays at zero.
          if (in_side.neg && q != '0) data_nxt.hue = HUE_FULL - q_ext;
          else if (in_side.neg) data_nxt.hue = '0;
          else data_nxt.hue = q_ext;
        end
        SEL_GREEN: begin
          data_nxt.hue = in_side.neg ? HUE_GREEN_BASE - q_ext : HUE_GREEN_BASE + q_ext;
        end
        SEL_BLUE: begin
          data_nxt.hue = in_side.neg ? HUE_BLUE_BASE - q_ext : HUE_BLUE_BASE + q_ext;
        end
        default: begin
          data_nxt.hue = '0;
        end
      endcase
    end
    data_nxt.saturation = in_side.black ? '0 : SAT_W'({{SAT_W{1'b0}}, in_quo[LANE_SAT]});
    data_nxt.brightness = VAL_W'({{VAL_W{1'b0}}, in_div[LANE_SAT]});
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: bench/rgb_to_hsv_converter_unit_test.sv
module rgb_to_hsv_converter_unit_test;
  import rhc_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_PIXELS = 1850;
  // Tail wait after the drain, long enough to cover the pipeline depth.
  localparam int TAIL_CYCLES   = 40;
  localparam int LONG_HOLD     = 200;
  localparam int HOLD_AFTER    = 40;
  localparam int MID_PAUSE_AT  = 900;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RUN_LIMIT     = 3000000;
  localparam int IN_BITS       = $bits(rhc_in_t);

  localparam int CHAN_FULL  = (1 << PIX_W) - 1;
  localparam int HUE_SECTOR = 60;
  localparam int DEG_FULL   = 360;
  localparam int DEG_GREEN  = 120;
  localparam int DEG_BLUE   = 240;

  // Classes of random pixels; uniform ones are drawn most often.
  typedef enum int {
    PK_UNIFORM,
    PK_GREY,
    PK_TIE,
    PK_RED_NEG,
    PK_NEAR_GREY,
    PK_SATURATED,
    PK_DARK
  } pix_kind_t;

  // Patterns of the result sink between its long hold-off.
  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_PERIODIC,
    RX_SLUGGISH
  } rx_mode_t;

  // One directed beat: the pixel, and a hand-typed result where it is obvious.
  typedef struct packed {
    rhc_in_t  px;
    logic     typed;
    rhc_out_t hsv;
  } directed_row_t;

  localparam rhc_out_t NO_HSV = '0;

  localparam directed_row_t DIRECTED [22] = '{
    // black, white and the primaries
    '{'{8'd0,   8'd0,   8'd0},   1'b1, '{9'd0,   8'd0,   8'd0}},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{9'd0,   8'd0,   8'd255}},
    '{'{8'd255, 8'd0,   8'd0},   1'b1, '{9'd0,   8'd255, 8'd255}},
    '{'{8'd0,   8'd255, 8'd0},   1'b1, '{9'd120, 8'd255, 8'd255}},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{9'd240, 8'd255, 8'd255}},
    // secondaries: ties for largest, red beats green beats blue
    '{'{8'd255, 8'd255, 8'd0},   1'b1, '{9'd60,  8'd255, 8'd255}},
    '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{9'd180, 8'd255, 8'd255}},
    '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{9'd300, 8'd255, 8'd255}},
    // greys
    '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{9'd0,   8'd0,   8'd128}},
    '{'{8'd1,   8'd1,   8'd1},   1'b1, '{9'd0,   8'd0,   8'd1}},
    // the rest go through the predictor
    '{'{8'd1,   8'd0,   8'd0},   1'b0, NO_HSV},
    '{'{8'd0,   8'd0,   8'd1},   1'b0, NO_HSV},
    '{'{8'd255, 8'd0,   8'd1},   1'b0, NO_HSV},
    '{'{8'd200, 8'd100, 8'd101}, 1'b0, NO_HSV},
    '{'{8'd255, 8'd0,   8'd128}, 1'b0, NO_HSV},
    '{'{8'd255, 8'd254, 8'd0},   1'b0, NO_HSV},
    '{'{8'd254, 8'd255, 8'd255}, 1'b0, NO_HSV},
    '{'{8'd1,   8'd0,   8'd1},   1'b0, NO_HSV},
    '{'{8'd100, 8'd50,  8'd200}, 1'b0, NO_HSV},
    '{'{8'd37,  8'd201, 8'd142}, 1'b0, NO_HSV},
    '{'{8'd255, 8'd1,   8'd0},   1'b0, NO_HSV},
    '{'{8'd170, 8'd85,  8'd85},  1'b0, NO_HSV}
  };

  logic     clk      = 1'b0;
  logic     rst_n    = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rhc_in_t  in_data  = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rhc_out_t out_data;

  // Side band that travels with the input beat: a hand-typed result, if any.
  logic     beat_typed     = 1'b0;
  rhc_out_t beat_typed_hsv = '0;

  rhc_out_t hsv_expected [$];
  int       mismatch_count = 0;
  int       pixels_sent    = 0;

  always #HALF_PERIOD clk = ~clk;

  rgb_to_hsv_converter_unit #(
    .CHANNEL_BITS(PIX_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Integer HSV of one pixel: max picks the sector, ties go red, then green.
  function automatic rhc_out_t predict_hsv(input rhc_in_t px);
    int r, g, b, mx, mn, delta, hue, sat;
    rhc_out_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    // Signed integer division truncates toward zero, so a small negative
    // fraction lands on 0 and is not wrapped.
    if (delta == 0) hue = 0;
    else if (mx == r) hue = (HUE_SECTOR * (g - b)) / delta;
    else if (mx == g) hue = (HUE_SECTOR * (b - r)) / delta + DEG_GREEN;
    else hue = (HUE_SECTOR * (r - g)) / delta + DEG_BLUE;
    if (hue < 0) hue += DEG_FULL;
    sat = (mx == 0) ? 0 : (delta * CHAN_FULL) / mx;
    res.hue        = HUE_W'(hue);
    res.saturation = SAT_W'(sat);
    res.brightness = VAL_W'(mx);
    return res;
  endfunction

  // Scoreboard: check each result beat against the oldest pending pixel,
  // then queue the expectation of any pixel taken at this edge.
  always @(posedge clk) begin : scoreboard
    rhc_out_t oldest;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (hsv_expected.size() == 0) begin
          $error("result beat with no pixel pending: hue %0d sat %0d val %0d",
                 out_data.hue, out_data.saturation, out_data.brightness);
          mismatch_count++;
        end else begin
          oldest = hsv_expected.pop_front();
          if (out_data.hue !== oldest.hue) begin
            $error("hue: expected %0d, got %0d", oldest.hue, out_data.hue);
            mismatch_count++;
          end
          if (out_data.saturation !== oldest.saturation) begin
            $error("saturation: expected %0d, got %0d",
                   oldest.saturation, out_data.saturation);
            mismatch_count++;
          end
          if (out_data.brightness !== oldest.brightness) begin
            $error("brightness: expected %0d, got %0d",
                   oldest.brightness, out_data.brightness);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        hsv_expected.push_back(beat_typed ? beat_typed_hsv : predict_hsv(in_data));
      end
    end
  end

  // Offer one pixel at the falling edge and hold it until the block takes it.
  task automatic send_pixel(input rhc_in_t px, input logic typed, input rhc_out_t hsv);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_data        <= px;
    beat_typed     <= typed;
    beat_typed_hsv <= hsv;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // Drop valid for a number of cycles; scramble the idle payload meanwhile.
  task automatic idle_input(input int cycles);
    @(negedge clk);
    in_valid   <= 1'b0;
    beat_typed <= 1'b0;
    in_data    <= rhc_in_t'(IN_BITS'($urandom));
    repeat (cycles - 1) @(negedge clk) in_data <= rhc_in_t'(IN_BITS'($urandom));
  endtask

  // Result sink: one long hold-off early on to back the pipeline up to the
  // input, then segments of free flow, coin flips, periodic and rare ready.
  initial begin : result_sink
    rx_mode_t mode;
    int seg_len, period;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && pixels_sent >= HOLD_AFTER) begin
        held = 1'b1;
        @(negedge clk) out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end
      mode    = rx_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(8, 64);
      period  = $urandom_range(2, 5);
      for (int k = 0; k < seg_len; k++) begin
        @(negedge clk);
        case (mode)
          RX_FREE:     out_ready <= 1'b1;
          RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ready <= (k % period == 0);
          default:     out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    rhc_in_t px;
    pix_kind_t kind;
    int roll, perm, burst_len, random_sent, drain_wait;
    logic [PIX_W-1:0] a, b, c, m;
    random_sent = 0;

    // Hold reset for a fixed count, release at a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed beats back to back.
    foreach (DIRECTED[i]) send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].hsv);

    // Random beats in bursts, most of them separated by random gaps.
    while (random_sent < RANDOM_PIXELS) begin
      burst_len = $urandom_range(1, 48);
      for (int n = 0; n < burst_len && random_sent < RANDOM_PIXELS; n++) begin
        roll = $urandom_range(0, 9);
        kind = (roll < 4) ? PK_UNIFORM : pix_kind_t'(roll - 3);
        a = PIX_W'($urandom_range(0, CHAN_FULL));
        b = PIX_W'($urandom_range(0, CHAN_FULL));
        c = PIX_W'($urandom_range(0, CHAN_FULL));
        case (kind)
          PK_GREY: begin
            b = a;
            c = a;
          end
          PK_TIE: begin
            m = a;
            b = m;
            c = PIX_W'($urandom_range(0, m));
          end
          PK_RED_NEG: begin
            // red largest, green not above blue: hue wraps or truncates to 0
            a = PIX_W'($urandom_range(1, CHAN_FULL));
            c = PIX_W'($urandom_range(0, a));
            b = PIX_W'($urandom_range(0, c));
          end
          PK_NEAR_GREY: begin
            b = PIX_W'(a + $urandom_range(0, 3));
            c = PIX_W'(a + $urandom_range(0, 3));
          end
          PK_SATURATED: begin
            a = PIX_W'(CHAN_FULL);
            b = '0;
          end
          PK_DARK: begin
            a = PIX_W'($urandom_range(0, 3));
            b = PIX_W'($urandom_range(0, 3));
            c = PIX_W'($urandom_range(0, 3));
          end
          default: ;
        endcase
        // Shuffle the channels, except where the red-largest order matters.
        perm = (kind == PK_RED_NEG) ? 0 : $urandom_range(0, 5);
        case (perm)
          0:       begin px.red = a; px.green = b; px.blue = c; end
          1:       begin px.red = a; px.green = c; px.blue = b; end
          2:       begin px.red = b; px.green = a; px.blue = c; end
          3:       begin px.red = b; px.green = c; px.blue = a; end
          4:       begin px.red = c; px.green = a; px.blue = b; end
          default: begin px.red = c; px.green = b; px.blue = a; end
        endcase
        send_pixel(px, 1'b0, NO_HSV);
        random_sent++;
        // Pause once until the pipeline has fully drained.
        if (random_sent == MID_PAUSE_AT) begin
          idle_input(1);
          while (hsv_expected.size() != 0) @(negedge clk);
        end
      end
      // Leave some bursts joined with no gap at all.
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
    end
    idle_input(1);

    // Wait out the remaining results, bounded.
    drain_wait = 0;
    while (hsv_expected.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_wait++;
    end
    if (hsv_expected.size() != 0) begin
      $error("%0d pixels never produced a result", hsv_expected.size());
      mismatch_count += hsv_expected.size();
    end
    // Give stray result beats a chance to show up.
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #RUN_LIMIT;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rhc_pkg.sv
rtl/core/rhc_front.sv
rtl/core/rhc_div_cell.sv
rtl/core/rhc_back.sv
rtl/core/rgb_to_hsv_converter_unit.sv
bench/rgb_to_hsv_converter_unit_test.sv
